// ===== hw/rtl/sfa_pkg.sv =====
`timescale 1ns / 1ps

package sfa_pkg;

  localparam int PixelBits  = 13;
  localparam int UvFracBits = 16;
  localparam int UvBits     = UvFracBits + 1;
  localparam int CfgIdxBits = 3;
  localparam int TimeBits   = 32;
  localparam int TimerBits  = 33;
  localparam int LenBits    = 9;

  localparam logic [CfgIdxBits-1:0] REG_MARGIN_X     = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_MARGIN_Y     = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_GAP_X        = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_GAP_Y        = 3'd5;
  localparam logic [CfgIdxBits-1:0] REG_SHEET_WIDTH  = 3'd6;
  localparam logic [CfgIdxBits-1:0] REG_SHEET_HEIGHT = 3'd7;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_PLAY = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [TimeBits-1:0] elapsed;
    logic [7:0]          clip_id;
    logic                restart_same;
    logic [7:0]          first_column;
    logic [7:0]          sheet_row;
    logic [LenBits-1:0]  clip_length;
    logic [TimeBits-1:0] hold_time;
    logic                looping;
  } in_t;

  typedef struct packed {
    logic              uv_valid;
    logic [UvBits-1:0] u_origin;
    logic [UvBits-1:0] v_origin;
    logic [UvBits-1:0] u_size;
    logic [UvBits-1:0] v_size;
    logic [7:0]        frame_number;
    logic              is_playing;
  } out_t;

  // frame count of a clip: zero counts as one, above 256 as 256
  function automatic logic [LenBits-1:0] clip_count(logic [LenBits-1:0] frames);
    logic [LenBits-1:0] c;
    c = frames;
    if (frames == '0) begin
      c = LenBits'(1);
    end else if (frames > LenBits'(256)) begin
      c = LenBits'(256);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sprite_frame_animator_uv.sv =====
// From acceptance, a result with a valid window passes S_WIN, S_WX and S_WY, four ratios
// (each a start step and a divide, or the start alone when saturated) and S_OUT; with no
// window S_WIN goes to S_OUT. A tick running the timer divide first passes S_DIV, S_TADV,
// and S_TMUL and S_TSUB if it clamps. One transaction at a time, accepted only once the
// last result is registered; set by the shared restoring divider and output back-pressure.
// Reset (rst_ni low, asynchronous): no clip, stopped, control registers zero, no result.
`timescale 1ns / 1ps

module sprite_frame_animator_uv import sfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [PixelBits-1:0]  cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o
);

  localparam int NumBits  = 24;
  localparam int ProdBits = LenBits + TimeBits;

  localparam logic [1:0] SEL_U0 = 2'd0;
  localparam logic [1:0] SEL_V0 = 2'd1;
  localparam logic [1:0] SEL_US = 2'd2;
  localparam logic [1:0] SEL_VS = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_TADV, S_TMUL, S_TSUB,
    S_WIN, S_WX, S_WY, S_RSTART, S_RDIV, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;

  logic [PixelBits-1:0] margin_x_q, margin_x_d, margin_y_q, margin_y_d;
  logic [PixelBits-1:0] cell_w_q, cell_w_d, cell_h_q, cell_h_d;
  logic [PixelBits-1:0] gap_x_q, gap_x_d, gap_y_q, gap_y_d;
  logic [PixelBits-1:0] sheet_w_q, sheet_w_d, sheet_h_q, sheet_h_d;

  logic                 loaded_q, loaded_d;
  logic [7:0]           cur_clip_q, cur_clip_d;
  logic [7:0]           first_col_q, first_col_d;
  logic [7:0]           row_q, row_d;
  logic [LenBits-1:0]   frames_q, frames_d;
  logic [TimeBits-1:0]  hold_q, hold_d;
  logic                 loops_q, loops_d;
  logic [7:0]           index_q, index_d;
  logic [TimerBits-1:0] timer_q, timer_d;
  logic                 running_q, running_d;

  logic [TimerBits-1:0] t_q, t_d;
  logic [TimeBits-1:0]  rem_q, rem_d;
  logic [TimerBits-1:0] dvd_q, dvd_d;
  logic [7:0]           qmod_q, qmod_d;
  logic [LenBits-1:0]   mul_a_q, mul_a_d;
  logic [TimeBits-1:0]  mul_b_q, mul_b_d;
  logic [ProdBits-1:0]  prod_q, prod_d;
  logic [NumBits-1:0]   x_q, x_d;
  logic [UvBits-1:0]    res_q [4];
  logic [UvBits-1:0]    res_d [4];

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // shared divider step
  logic [TimeBits-1:0]  div_den;
  logic [TimerBits-1:0] rem_sh, rem_sub;
  logic                 div_ge;
  logic [TimeBits-1:0]  rem_nx;
  logic [TimerBits-1:0] dvd_nx;
  logic [LenBits-1:0]   m2;
  logic [7:0]           qmod_nx;

  logic [LenBits-1:0]   count;
  logic [PixelBits-1:0] rat_den;
  logic [NumBits-1:0]   rat_num, bottom;
  logic [PixelBits-1:0] fy;
  logic                 rat_sat;
  logic [TimerBits:0]   tsum;
  logic [TimerBits-1:0] t_sat;
  logic [LenBits-1:0]   left, sum9;
  logic                 win_ok;

  assign count   = clip_count(frames_q);
  assign rat_den = sel_q[0] ? sheet_h_q : sheet_w_q;
  assign div_den = (state_q == S_DIV) ? hold_q : TimeBits'(rat_den);

  assign rem_sh  = {rem_q, dvd_q[TimerBits-1]};
  assign div_ge  = rem_sh >= {1'b0, div_den};
  assign rem_sub = rem_sh - {1'b0, div_den};
  assign rem_nx  = div_ge ? rem_sub[TimeBits-1:0] : rem_sh[TimeBits-1:0];
  assign dvd_nx  = {dvd_q[TimerBits-2:0], div_ge};
  assign m2      = {qmod_q, div_ge};
  assign qmod_nx = (m2 >= count) ? 8'(m2 - count) : m2[7:0];

  assign bottom = NumBits'(margin_y_q) + prod_q[NumBits-1:0] + NumBits'(cell_h_q);
  assign fy     = (NumBits'(sheet_h_q) > bottom) ? (sheet_h_q - bottom[PixelBits-1:0]) : '0;

  always_comb begin
    case (sel_q)
      SEL_U0:  rat_num = x_q;
      SEL_V0:  rat_num = NumBits'(fy);
      SEL_US:  rat_num = NumBits'(cell_w_q);
      default: rat_num = NumBits'(cell_h_q);
    endcase
  end

  assign rat_sat = rat_num >= NumBits'({rat_den, 1'b0});
  assign tsum    = {1'b0, timer_q} + (TimerBits + 1)'(in_data_i.elapsed);
  assign t_sat   = tsum[TimerBits] ? '1 : tsum[TimerBits-1:0];
  assign left    = count - LenBits'(index_q);
  assign sum9    = LenBits'(index_q) + LenBits'(qmod_q);
  assign win_ok  = loaded_q && (sheet_w_q != '0) && (sheet_h_q != '0);
  assign prod_d  = ProdBits'(mul_a_q) * ProdBits'(mul_b_q);

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sel_d       = sel_q;
    margin_x_d  = margin_x_q;
    margin_y_d  = margin_y_q;
    cell_w_d    = cell_w_q;
    cell_h_d    = cell_h_q;
    gap_x_d     = gap_x_q;
    gap_y_d     = gap_y_q;
    sheet_w_d   = sheet_w_q;
    sheet_h_d   = sheet_h_q;
    loaded_d    = loaded_q;
    cur_clip_d  = cur_clip_q;
    first_col_d = first_col_q;
    row_d       = row_q;
    frames_d    = frames_q;
    hold_d      = hold_q;
    loops_d     = loops_q;
    index_d     = index_q;
    timer_d     = timer_q;
    running_d   = running_q;
    t_d         = t_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    qmod_d      = qmod_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    x_d         = x_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MARGIN_X:     margin_x_d = cfg_data_i;
        REG_MARGIN_Y:     margin_y_d = cfg_data_i;
        REG_CELL_WIDTH:   cell_w_d   = cfg_data_i;
        REG_CELL_HEIGHT:  cell_h_d   = cfg_data_i;
        REG_GAP_X:        gap_x_d    = cfg_data_i;
        REG_GAP_Y:        gap_y_d    = cfg_data_i;
        REG_SHEET_WIDTH:  sheet_w_d  = cfg_data_i;
        REG_SHEET_HEIGHT: sheet_h_d  = cfg_data_i;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_WIN;
          case (in_data_i.mode)
            MODE_TICK: begin
              if (running_q && loaded_q) begin
                if (hold_q == '0) begin
                  timer_d = t_sat;
                end else begin
                  t_d     = t_sat;
                  rem_d   = '0;
                  dvd_d   = t_sat;
                  qmod_d  = '0;
                  cnt_d   = 6'(TimerBits - 1);
                  state_d = S_DIV;
                end
              end
            end
            MODE_PLAY: begin
              if (!(loaded_q && in_data_i.clip_id == cur_clip_q &&
                    !in_data_i.restart_same)) begin
                loaded_d    = 1'b1;
                cur_clip_d  = in_data_i.clip_id;
                first_col_d = in_data_i.first_column;
                row_d       = in_data_i.sheet_row;
                frames_d    = in_data_i.clip_length;
                hold_d      = in_data_i.hold_time;
                loops_d     = in_data_i.looping;
                index_d     = '0;
                timer_d     = '0;
              end
              running_d = 1'b1;
            end
            MODE_STOP: running_d = 1'b0;
            default: ;
          endcase
        end
      end
      // timer / hold, quotient also reduced modulo the frame count
      S_DIV: begin
        rem_d  = rem_nx;
        dvd_d  = dvd_nx;
        qmod_d = qmod_nx;
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = S_TADV;
        end
      end
      S_TADV: begin
        state_d = S_WIN;
        if (loops_q) begin
          index_d = (sum9 >= count) ? 8'(sum9 - count) : sum9[7:0];
          timer_d = TimerBits'(rem_q);
        end else if (dvd_q >= TimerBits'(left)) begin
          index_d   = 8'(count - LenBits'(1));
          running_d = 1'b0;
          mul_a_d   = left;
          mul_b_d   = hold_q;
          state_d   = S_TMUL;
        end else begin
          index_d = index_q + dvd_q[7:0];
          timer_d = TimerBits'(rem_q);
        end
      end
      S_TMUL: state_d = S_TSUB;
      S_TSUB: begin
        timer_d = t_q - prod_q[TimerBits-1:0];
        state_d = S_WIN;
      end
      S_WIN: begin
        if (win_ok) begin
          mul_a_d = LenBits'(first_col_q) + LenBits'(index_q);
          mul_b_d = TimeBits'({1'b0, cell_w_q} + {1'b0, gap_x_q});
          state_d = S_WX;
        end else begin
          state_d = S_OUT;
        end
      end
      S_WX: begin
        mul_a_d = LenBits'(row_q);
        mul_b_d = TimeBits'({1'b0, cell_h_q} + {1'b0, gap_y_q});
        state_d = S_WY;
      end
      S_WY: begin
        x_d     = NumBits'(margin_x_q) + prod_q[NumBits-1:0];
        sel_d   = SEL_U0;
        state_d = S_RSTART;
      end
      S_RSTART: begin
        if (rat_sat) begin
          res_d[sel_q] = '1;
          sel_d        = sel_q + 2'd1;
          if (sel_q == SEL_VS) begin
            state_d = S_OUT;
          end
        end else begin
          rem_d   = TimeBits'(rat_num[NumBits-1:1]);
          dvd_d   = {rat_num[0], {(TimerBits-1){1'b0}}};
          cnt_d   = 6'(UvBits - 1);
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        rem_d = rem_nx;
        dvd_d = dvd_nx;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          res_d[sel_q] = dvd_nx[UvBits-1:0];
          sel_d        = sel_q + 2'd1;
          state_d      = (sel_q == SEL_VS) ? S_OUT : S_RSTART;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.uv_valid     = win_ok;
          out_d.u_origin     = win_ok ? res_q[SEL_U0] : '0;
          out_d.v_origin     = win_ok ? res_q[SEL_V0] : '0;
          out_d.u_size       = win_ok ? res_q[SEL_US] : '0;
          out_d.v_size       = win_ok ? res_q[SEL_VS] : '0;
          out_d.frame_number = index_q;
          out_d.is_playing   = running_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sel_q       <= SEL_U0;
      margin_x_q  <= '0;
      margin_y_q  <= '0;
      cell_w_q    <= '0;
      cell_h_q    <= '0;
      gap_x_q     <= '0;
      gap_y_q     <= '0;
      sheet_w_q   <= '0;
      sheet_h_q   <= '0;
      loaded_q    <= 1'b0;
      cur_clip_q  <= '0;
      first_col_q <= '0;
      row_q       <= '0;
      frames_q    <= '0;
      hold_q      <= '0;
      loops_q     <= 1'b0;
      index_q     <= '0;
      timer_q     <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sel_q       <= sel_d;
      margin_x_q  <= margin_x_d;
      margin_y_q  <= margin_y_d;
      cell_w_q    <= cell_w_d;
      cell_h_q    <= cell_h_d;
      gap_x_q     <= gap_x_d;
      gap_y_q     <= gap_y_d;
      sheet_w_q   <= sheet_w_d;
      sheet_h_q   <= sheet_h_d;
      loaded_q    <= loaded_d;
      cur_clip_q  <= cur_clip_d;
      first_col_q <= first_col_d;
      row_q       <= row_d;
      frames_q    <= frames_d;
      hold_q      <= hold_d;
      loops_q     <= loops_d;
      index_q     <= index_d;
      timer_q     <= timer_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    qmod_q  <= qmod_d;
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
    prod_q  <= prod_d;
    x_q     <= x_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule
